### hdl/ufe_pkg.sv
// Shared package of the union-find engine: field widths, output limits,
// and the command and status types between the controller and the datapath.
// Depends on nothing.
package ufe_pkg;

    localparam int ELEMENTS_DEF = 1024;
    localparam int IN_W         = 10;
    localparam int STEP_W       = 1;
    localparam int ROOT_W       = 10;
    localparam int SIZE_OUT_W   = 11;
    localparam int SIZE_SAT     = 2047;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_REDUCE,
        OP_FSTART,
        OP_FWALK,
        OP_CSTART,
        OP_CWALK,
        OP_SZA,
        OP_SZB,
        OP_LINK,
        OP_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic reduce_last;
        logic walk_hit;
        logic comp_skip;
        logic comp_end;
        logic is_union;
        logic out_free;
    } t_dp_sts;

endpackage

### hdl/ufe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Read during a write to the same address returns the old contents.
// Depends on nothing.
module ufe_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ufe_datapath.sv
// Datapath of the union-find engine: operand reduction, parent and size tables,
// root walk, path compression, linking and the output register.
// Depends on ufe_pkg and ufe_ram.
module ufe_datapath
    import ufe_pkg::*;
#(
    parameter int ELEMENTS = ELEMENTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tuser
);

    localparam int IDX_W  = $clog2(ELEMENTS);
    localparam int SIZE_W = IDX_W + 1;
    localparam int RED_L  = $clog2(ELEMENTS);
    localparam int RED_S  = IN_W + RED_L;
    localparam int RED_M  = ((1 << RED_S) + ELEMENTS - 1) / ELEMENTS;

    logic [IDX_W-1:0]  r_cur;
    logic [IDX_W-1:0]  r_root;
    logic [IDX_W-1:0]  r_ra;
    logic [IDX_W-1:0]  r_rb;
    logic [SIZE_W-1:0] r_sa;
    logic [SIZE_W-1:0] r_size;
    logic              r_merged;
    logic              r_cmd;
    logic [IN_W-1:0]   r_va;
    logic [IN_W-1:0]   r_vb;
    logic [IN_W-1:0]   r_qa;
    logic [IN_W-1:0]   r_qb;
    logic [STEP_W-1:0] r_step;

    logic                  r_out_valid;
    logic [ROOT_W-1:0]     r_out_root;
    logic [SIZE_OUT_W-1:0] r_out_size;
    logic                  r_out_merged;

    logic              par_we;
    logic [IDX_W-1:0]  par_waddr;
    logic [IDX_W-1:0]  par_wdata;
    logic [IDX_W-1:0]  par_raddr;
    logic [IDX_W-1:0]  par_rdata;
    logic              size_we;
    logic [IDX_W-1:0]  size_waddr;
    logic [SIZE_W-1:0] size_wdata;
    logic [IDX_W-1:0]  size_raddr;
    logic [SIZE_W-1:0] size_rdata;

    logic [31:0]       va_ext;
    logic [31:0]       vb_ext;
    logic [31:0]       qa_prod;
    logic [31:0]       qb_prod;
    logic [IN_W-1:0]   qa;
    logic [IN_W-1:0]   qb;
    logic [IDX_W-1:0]  elem;
    logic [IN_W-1:0]   va_red;
    logic [IN_W-1:0]   vb_red;
    logic              do_merge;
    logic              swap;
    logic [IDX_W-1:0]  winner;
    logic [IDX_W-1:0]  loser;
    logic [SIZE_W:0]   sum_wide;
    logic [SIZE_W-1:0] sum;
    logic [31:0]       root_ext;
    logic [31:0]       size_ext;

    ufe_ram #(.WIDTH(IDX_W), .DEPTH(ELEMENTS)) u_parent (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    ufe_ram #(.WIDTH(SIZE_W), .DEPTH(ELEMENTS)) u_size (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (size_waddr),
        .i_wdata (size_wdata),
        .i_raddr (size_raddr),
        .o_rdata (size_rdata)
    );

    // Reduction modulo ELEMENTS by a reciprocal multiplication: the quotient
    // is formed and registered first, and the remainder is then formed from it.
    always_comb begin
        va_ext  = 32'(r_va);
        vb_ext  = 32'(r_vb);
        qa_prod = va_ext * 32'(RED_M);
        qb_prod = vb_ext * 32'(RED_M);
        qa      = IN_W'(qa_prod >> RED_S);
        qb      = IN_W'(qb_prod >> RED_S);
        va_red  = IN_W'(va_ext - 32'(r_qa) * 32'(ELEMENTS));
        vb_red  = IN_W'(vb_ext - 32'(r_qb) * 32'(ELEMENTS));
    end

    assign elem = i_cmd.sel ? vb_ext[IDX_W-1:0] : va_ext[IDX_W-1:0];

    assign do_merge = r_cmd && (r_ra != r_rb);
    assign swap     = size_rdata > r_sa;
    assign winner   = swap ? r_rb : r_ra;
    assign loser    = swap ? r_ra : r_rb;
    assign sum_wide = {1'b0, r_sa} + {1'b0, size_rdata};
    assign sum      = sum_wide[SIZE_W-1:0];
    assign root_ext = 32'(r_root);
    assign size_ext = 32'(r_size);

    always_comb begin
        par_we     = 1'b0;
        par_waddr  = r_cur;
        par_wdata  = r_root;
        par_raddr  = r_cur;
        size_we    = 1'b0;
        size_waddr = r_cur;
        size_wdata = SIZE_W'(1);
        size_raddr = r_ra;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                par_we    = 1'b1;
                par_wdata = r_cur;
                size_we   = 1'b1;
            end
            OP_FSTART, OP_CSTART: begin
                par_raddr = elem;
            end
            OP_FWALK: begin
                par_raddr = par_rdata;
            end
            OP_CWALK: begin
                par_we    = 1'b1;
                par_raddr = par_rdata;
            end
            OP_SZB: begin
                size_raddr = r_rb;
            end
            OP_LINK: begin
                par_we     = do_merge;
                par_waddr  = loser;
                par_wdata  = winner;
                size_we    = do_merge;
                size_waddr = winner;
                size_wdata = sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_CLEAR: begin
                    r_cur <= r_cur + IDX_W'(1);
                end
                OP_ACCEPT: begin
                    r_cmd  <= i_s_tuser;
                    r_va   <= i_s_tdata[IN_W-1:0];
                    r_vb   <= i_s_tdata[2*IN_W-1:IN_W];
                    r_step <= STEP_W'(1);
                end
                OP_REDUCE: begin
                    if (r_step != '0) begin
                        r_qa <= qa;
                        r_qb <= qb;
                    end else begin
                        r_va <= va_red;
                        r_vb <= vb_red;
                    end
                    r_step <= r_step - STEP_W'(1);
                end
                OP_FSTART, OP_CSTART: begin
                    r_cur <= elem;
                end
                OP_FWALK: begin
                    if (par_rdata == r_cur) begin
                        r_root <= r_cur;
                        if (i_cmd.sel) begin
                            r_rb <= r_cur;
                        end else begin
                            r_ra <= r_cur;
                        end
                    end else begin
                        r_cur <= par_rdata;
                    end
                end
                OP_CWALK: begin
                    r_cur <= par_rdata;
                end
                OP_SZB: begin
                    r_sa <= size_rdata;
                end
                OP_LINK: begin
                    if (do_merge) begin
                        r_root   <= winner;
                        r_size   <= sum;
                        r_merged <= 1'b1;
                    end else begin
                        r_root   <= r_ra;
                        r_size   <= r_sa;
                        r_merged <= 1'b0;
                    end
                end
                OP_LOAD: begin
                    r_out_root   <= root_ext[ROOT_W-1:0];
                    r_out_merged <= r_merged;
                    r_out_size   <= (size_ext > 32'(SIZE_SAT)) ? SIZE_OUT_W'(SIZE_SAT)
                                                              : size_ext[SIZE_OUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.clear_last  = (r_cur == IDX_W'(ELEMENTS - 1));
    assign o_sts.reduce_last = (r_step == '0);
    assign o_sts.walk_hit    = (par_rdata == r_cur);
    assign o_sts.comp_skip   = (elem == r_root);
    assign o_sts.comp_end    = (par_rdata == r_root);
    assign o_sts.is_union    = r_cmd;
    assign o_sts.out_free    = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_merged;
    assign o_m_tdata  = {{(M_TDATA_W - ROOT_W - SIZE_OUT_W){1'b0}}, r_out_size, r_out_root};

endmodule

### hdl/ufe_ctrl.sv
// Controller of the union-find engine: the sequence of table sweep, operand
// reduction, root walks, compression, linking and result hand-over.
// Depends on ufe_pkg.
module ufe_ctrl
    import ufe_pkg::*;
#(
    parameter int ELEMENTS = ELEMENTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam bit NEED_MOD = ELEMENTS < (1 << IN_W);

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_REDUCE = 11'b000_0000_0100,
        ST_FSTART = 11'b000_0000_1000,
        ST_FWALK  = 11'b000_0001_0000,
        ST_CSTART = 11'b000_0010_0000,
        ST_CWALK  = 11'b000_0100_0000,
        ST_SZA    = 11'b000_1000_0000,
        ST_SZB    = 11'b001_0000_0000,
        ST_LINK   = 11'b010_0000_0000,
        ST_RESULT = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_sel;
    logic   n_sel;
    t_state after_find;

    always_comb begin
        after_find = (!r_sel && i_sts.is_union) ? ST_FSTART : ST_SZA;
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = r_sel;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_sel    = 1'b0;
                    n_state  = NEED_MOD ? ST_REDUCE : ST_FSTART;
                end
            end
            ST_REDUCE: begin
                o_cmd.op = OP_REDUCE;
                if (i_sts.reduce_last) begin
                    n_state = ST_FSTART;
                end
            end
            ST_FSTART: begin
                o_cmd.op = OP_FSTART;
                n_state  = ST_FWALK;
            end
            ST_FWALK: begin
                o_cmd.op = OP_FWALK;
                if (i_sts.walk_hit) begin
                    n_state = ST_CSTART;
                end
            end
            ST_CSTART: begin
                o_cmd.op = OP_CSTART;
                if (i_sts.comp_skip) begin
                    n_state = after_find;
                    n_sel   = 1'b1;
                end else begin
                    n_state = ST_CWALK;
                end
            end
            ST_CWALK: begin
                o_cmd.op = OP_CWALK;
                if (i_sts.comp_end) begin
                    n_state = after_find;
                    n_sel   = 1'b1;
                end
            end
            ST_SZA: begin
                o_cmd.op = OP_SZA;
                n_state  = ST_SZB;
            end
            ST_SZB: begin
                o_cmd.op = OP_SZB;
                n_state  = ST_LINK;
            end
            ST_LINK: begin
                o_cmd.op = OP_LINK;
                n_state  = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

### hdl/union_find_engine_unit.sv
// Top level of the union-find engine: a disjoint-set store with path
// compression and union by size, over ELEMENTS elements.
// Depends on ufe_pkg, ufe_ctrl, ufe_datapath and ufe_ram.
//
// The slave channel takes one command word at a time: tuser is the command
// (find or union), tdata carries the two element indexes. The master channel
// returns one word per command: tdata holds the root and the set size,
// tuser says whether a union joined two distinct sets.
// After reset the parent and size tables are swept, one entry per cycle, over
// all ELEMENTS entries; o_s_tready stays low until the sweep is over.
// A find walks from the element up to its root and then compresses that path
// before its result is loaded into the output register; a union does so for
// both of its elements, then reads the two set sizes and links the roots. Each
// hop of a walk or of the compression pass is one read of the parent table,
// so the depth of an element in its tree sets the time. The next word is
// accepted in the cycle after the result is loaded. When ELEMENTS is below
// 1024 the indexes are first reduced modulo ELEMENTS, quotient then remainder.
// The result waits in an output register while the receiver stalls; the
// block accepts the next word as soon as the previous one has reached that
// register, and holds a finished result until the register is free.
module union_find_engine_unit
    import ufe_pkg::*;
#(
    parameter int ELEMENTS = ELEMENTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // first_element, second_element
    input  logic                 i_s_tuser,  // command
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // root, set_size
    output logic                 o_m_tuser   // merged
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ufe_ctrl #(.ELEMENTS(ELEMENTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    ufe_datapath #(.ELEMENTS(ELEMENTS)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_LOAD) |-> (!o_m_tvalid || i_m_tready))
        else $error("Result loaded over a word still waiting.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("Second word taken while one is in progress.");

    a_merged_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[20:10] >= 11'd2))
        else $error("Merged result with a set of fewer than two elements.");

    a_accept_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_ACCEPT) |-> (o_s_tready && i_s_tvalid))
        else $error("Operands latched without a handshake.");

endmodule
